[design/dpc_pkg.sv]
// dpc_pkg: shared types, codes and helpers for the debounced press classifier
// no dependencies; used by every module of the block
`default_nettype none

package dpc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CfgAddrW = 8;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;

  localparam logic [MsW-1:0] Sat16 = 16'hFFFF;

  localparam logic [MsW-1:0] DebounceRst = 16'd20;
  localparam logic [MsW-1:0] ShortMinRst = 16'd50;
  localparam logic [MsW-1:0] GraceRst    = 16'd1500;
  localparam logic           AssertLvlRst = 1'b0;

  typedef enum logic [2:0] {
    EV_ASSERT       = 3'd0,
    EV_DEASSERT     = 3'd1,
    EV_SHORT        = 3'd2,
    EV_LONG_RELEASE = 3'd3,
    EV_LONG_TIMEOUT = 3'd4
  } evt_code_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_DEBOUNCE   = 8'd0,
    REG_SHORT_MIN  = 8'd1,
    REG_GRACE      = 8'd2,
    REG_ASSERT_LVL = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] short_min_ms;
    logic [MsW-1:0] grace_ms;
    logic           assert_level;
  } cfg_t;

  typedef struct packed {
    evt_code_e        event_code;
    logic [TimeW-1:0] event_time;
    logic [MsW-1:0]   event_arg;
    logic             is_pressed;
    logic [MsW-1:0]   last_press;
    logic             last_of_run;
  } result_t;

  function automatic logic [MsW-1:0] sat16(input logic [TimeW-1:0] v);
    logic [MsW-1:0] r;
    r = (v > {{(TimeW-MsW){1'b0}}, Sat16}) ? Sat16 : v[MsW-1:0];
    return r;
  endfunction

  // tdata: event_code, event_time, event_arg, is_pressed, last_press, zero fill
  function automatic logic [OutDataW-1:0] pack_result(input result_t r);
    logic [OutDataW-1:0] d;
    d = {4'b0, r.last_press, r.is_pressed, r.event_arg, r.event_time, r.event_code};
    return d;
  endfunction

endpackage

`default_nettype wire

[design/dpc_cfg.sv]
// dpc_cfg: configuration register bank of the press classifier
// depends on dpc_pkg for the register indexes and the cfg_t bundle
`default_nettype none

module dpc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [dpc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [dpc_pkg::MsW-1:0]      cfg_data_i,
  output dpc_pkg::cfg_t                     cfg_o
);

  dpc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        dpc_pkg::REG_DEBOUNCE:   cfg_d.debounce_ms  = cfg_data_i;
        dpc_pkg::REG_SHORT_MIN:  cfg_d.short_min_ms = cfg_data_i;
        dpc_pkg::REG_GRACE:      cfg_d.grace_ms     = cfg_data_i;
        dpc_pkg::REG_ASSERT_LVL: cfg_d.assert_level = cfg_data_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms  <= dpc_pkg::DebounceRst;
      cfg_q.short_min_ms <= dpc_pkg::ShortMinRst;
      cfg_q.grace_ms     <= dpc_pkg::GraceRst;
      cfg_q.assert_level <= dpc_pkg::AssertLvlRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/dpc_eval.sv]
// dpc_eval: debounce state and single-pass event evaluation of one poll word
// depends on dpc_pkg; fed from the input register, feeds the result buffer
`default_nettype none

module dpc_eval (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dpc_pkg::cfg_t             cfg_i,
  input  wire logic                      fire_i,
  input  wire logic [dpc_pkg::TimeW-1:0] now_i,
  input  wire logic                      level_i,
  output dpc_pkg::result_t               res0_o,
  output dpc_pkg::result_t               res1_o,
  output logic [1:0]                     n_res_o
);

  logic                      stable_q, stable_d;
  logic [dpc_pkg::TimeW-1:0] edge_time_q, edge_time_d;
  logic                      pressed_q, pressed_d;
  logic [dpc_pkg::TimeW-1:0] start_q, start_d;
  logic                      long_q, long_d;
  logic [dpc_pkg::MsW-1:0]   last_q, last_d;

  logic [dpc_pkg::TimeW-1:0] edge_diff;
  logic [dpc_pkg::TimeW-1:0] held;
  logic [dpc_pkg::MsW-1:0]   rel_dur;
  logic                      chg;
  logic                      has_edge, has_cls, has_to;
  dpc_pkg::evt_code_e        edge_code, cls_code;
  logic [dpc_pkg::MsW-1:0]   cls_arg;

  assign edge_diff = now_i - edge_time_q;
  assign chg = (level_i != stable_q) &&
               (edge_diff >= {{(dpc_pkg::TimeW-dpc_pkg::MsW){1'b0}}, cfg_i.debounce_ms});
  assign rel_dur = dpc_pkg::sat16(now_i - start_q);

  always_comb begin
    stable_d    = stable_q;
    edge_time_d = edge_time_q;
    pressed_d   = pressed_q;
    start_d     = start_q;
    long_d      = long_q;
    last_d      = last_q;
    has_edge    = 1'b0;
    has_cls     = 1'b0;
    edge_code   = dpc_pkg::EV_ASSERT;
    cls_code    = dpc_pkg::EV_SHORT;
    cls_arg     = rel_dur;

    if (chg) begin
      has_edge    = 1'b1;
      edge_time_d = now_i;
      stable_d    = level_i;
      if (level_i == cfg_i.assert_level) begin
        edge_code = dpc_pkg::EV_ASSERT;
        pressed_d = 1'b1;
        start_d   = now_i;
        long_d    = 1'b0;
      end else begin
        edge_code = dpc_pkg::EV_DEASSERT;
        if (pressed_q) begin
          last_d = rel_dur;
          if (!long_q) begin
            if (rel_dur >= cfg_i.grace_ms) begin
              has_cls  = 1'b1;
              cls_code = dpc_pkg::EV_LONG_RELEASE;
            end else if (rel_dur >= cfg_i.short_min_ms) begin
              has_cls  = 1'b1;
              cls_code = dpc_pkg::EV_SHORT;
            end
          end
        end
        pressed_d = 1'b0;
        start_d   = '0;
        long_d    = 1'b0;
      end
    end

    // hold timeout, judged on the state left by the edge step
    held   = now_i - start_d;
    has_to = pressed_d && !long_d &&
             (held >= {{(dpc_pkg::TimeW-dpc_pkg::MsW){1'b0}}, cfg_i.grace_ms});
    if (has_to) begin
      long_d = 1'b1;
    end
  end

  always_comb begin
    n_res_o = {1'b0, has_edge} + {1'b0, has_cls} + {1'b0, has_to};

    res0_o.event_time  = now_i;
    res0_o.is_pressed  = pressed_d;
    res0_o.last_press  = last_d;
    res0_o.last_of_run = (n_res_o == 2'd1);
    if (has_edge) begin
      res0_o.event_code = edge_code;
      res0_o.event_arg  = {{(dpc_pkg::MsW-1){1'b0}}, level_i};
    end else begin
      res0_o.event_code = dpc_pkg::EV_LONG_TIMEOUT;
      res0_o.event_arg  = dpc_pkg::sat16(held);
    end

    res1_o.event_time  = now_i;
    res1_o.is_pressed  = pressed_d;
    res1_o.last_press  = last_d;
    res1_o.last_of_run = 1'b1;
    if (has_cls) begin
      res1_o.event_code = cls_code;
      res1_o.event_arg  = cls_arg;
    end else begin
      res1_o.event_code = dpc_pkg::EV_LONG_TIMEOUT;
      res1_o.event_arg  = dpc_pkg::sat16(held);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q    <= ~dpc_pkg::AssertLvlRst;
      edge_time_q <= '0;
      pressed_q   <= 1'b0;
      start_q     <= '0;
      long_q      <= 1'b0;
      last_q      <= '0;
    end else if (fire_i) begin
      stable_q    <= stable_d;
      edge_time_q <= edge_time_d;
      pressed_q   <= pressed_d;
      start_q     <= start_d;
      long_q      <= long_d;
      last_q      <= last_d;
    end
  end

endmodule

`default_nettype wire

[design/dpc_obuf.sv]
// dpc_obuf: two-entry result register that hands out the words of one poll
// depends on dpc_pkg for result_t; loads all results of a poll at once
`default_nettype none

module dpc_obuf (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire logic [1:0] n_i,
  input  wire dpc_pkg::result_t r0_i,
  input  wire dpc_pkg::result_t r1_i,
  output logic            can_load_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output dpc_pkg::result_t data_o
);

  dpc_pkg::result_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign valid_o    = (cnt_q != 2'd0);
  assign pop        = valid_o && ready_i;
  // only load once the buffer is empty or drains its last word this cycle
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);
  assign data_o     = slot0_q;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      slot0_d = r0_i;
      slot1_d = r1_i;
      cnt_d   = n_i;
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

[design/debounced_press_classifier.sv]
// Debounced button press classifier. Each input word is one poll (ms timestamp
// and raw pin level); the block emits edge events and short/long press events.
// A poll that yields at most one event is taken every cycle while the output
// accepts words; a poll that yields two events holds the input side until the
// result buffer has handed out the first of the two words. On its way to the
// output a poll passes the input register, then the result register. Config
// is written through the cfg channel, which is always ready, and must only
// change while the block is idle. Depends on dpc_pkg, dpc_cfg, dpc_eval, dpc_obuf.
`default_nettype none

module debounced_press_classifier (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: now_time[31:0], pin_level[32], zero fill [39:33]
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [dpc_pkg::InDataW-1:0]     s_axis_tdata,
  // tdata: event_code[2:0], event_time[34:3], event_arg[50:35],
  //        is_pressed[51], last_press[67:52], zero fill [71:68]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [dpc_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dpc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [dpc_pkg::MsW-1:0]         cfg_data_i
);

  dpc_pkg::cfg_t             cfg;
  logic                      in_valid_q;
  logic [dpc_pkg::TimeW-1:0] in_now_q;
  logic                      in_level_q;
  logic                      can_load, proc;
  dpc_pkg::result_t          res0, res1, out_res;
  logic [1:0]                n_res;

  dpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign proc          = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_now_q   <= s_axis_tdata[dpc_pkg::TimeW-1:0];
      in_level_q <= s_axis_tdata[dpc_pkg::TimeW];
    end
  end

  dpc_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .fire_i  (proc),
    .now_i   (in_now_q),
    .level_i (in_level_q),
    .res0_o  (res0),
    .res1_o  (res1),
    .n_res_o (n_res)
  );

  dpc_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (proc),
    .n_i        (n_res),
    .r0_i       (res0),
    .r1_i       (res1),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (out_res)
  );

  assign m_axis_tdata = dpc_pkg::pack_result(out_res);
  assign m_axis_tlast = out_res.last_of_run;

endmodule

`default_nettype wire

[design/dpc_checker.sv]
// dpc_checker: port-level checks of the press classifier, bound to the top level
// depends on dpc_pkg for event codes; sees only the ports of the top level
`default_nettype none

module dpc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [dpc_pkg::OutDataW-1:0]    m_axis_tdata,
  input wire logic                            m_axis_tlast
);

  logic [2:0] code;
  assign code = m_axis_tdata[2:0];

  // a stalled word holds still
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  // with nothing waiting at the output, a poll word is always taken
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // edge events carry only the pin level
  a_edge_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (code == dpc_pkg::EV_ASSERT || code == dpc_pkg::EV_DEASSERT)
      |-> m_axis_tdata[50:36] == 15'd0)
    else $error("edge event with wide argument");

  // pressed flag agrees with the kind of event
  a_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (code == dpc_pkg::EV_ASSERT || code == dpc_pkg::EV_LONG_TIMEOUT)
      |-> m_axis_tdata[51])
    else $error("press event without pressed state");

  a_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (code == dpc_pkg::EV_DEASSERT || code == dpc_pkg::EV_SHORT ||
      code == dpc_pkg::EV_LONG_RELEASE) |-> !m_axis_tdata[51])
    else $error("release event with pressed state");

endmodule

bind debounced_press_classifier dpc_checker u_dpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
